### hdl/eadec_pkg.sv
// Package for the x86 effective address decoder.
// Holds the item types, field codes and the 16-bit addressing tables.
// No dependencies.
package eadec_pkg;

    // Address and mode size codes; code 3 acts as 64-bit.
    localparam logic [1:0] SZ_16 = 2'd0;
    localparam logic [1:0] SZ_32 = 2'd1;
    localparam logic [1:0] SZ_64 = 2'd2;

    // Displacement kinds.
    localparam logic [1:0] DISP_NONE = 2'd0;
    localparam logic [1:0] DISP_8    = 2'd1;
    localparam logic [1:0] DISP_16   = 2'd2;
    localparam logic [1:0] DISP_32   = 2'd3;

    // Explicit size hints.
    localparam logic [1:0] HINT_NONE  = 2'd0;
    localparam logic [1:0] HINT_WORD  = 2'd1;
    localparam logic [1:0] HINT_DWORD = 2'd2;

    // ModRM mod field values and special rm / SIB codes.
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISPW  = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;
    localparam logic [2:0] RM_DISP16  = 3'd6;
    localparam logic [2:0] SIB_NO_IDX = 3'd4;
    localparam logic [2:0] SIB_NO_BASE = 3'd5;

    // Register numbers used by 16-bit addressing.
    localparam logic [3:0] REG_BX = 4'd3;
    localparam logic [3:0] REG_BP = 4'd5;
    localparam logic [3:0] REG_SI = 4'd6;
    localparam logic [3:0] REG_DI = 4'd7;

    // 16-bit base register by rm, index register by rm[1:0] (rm 0..3).
    localparam logic [3:0] BASE16 [8] = '{REG_BX, REG_BX, REG_BP, REG_BP,
                                          REG_SI, REG_DI, REG_BP, REG_BX};
    localparam logic [3:0] INDEX16 [4] = '{REG_SI, REG_DI, REG_SI, REG_DI};

    typedef struct packed {
        logic [7:0]  modrm_byte;
        logic [39:0] following_bytes;
        logic [1:0]  addr_size;
        logic        rex_b_bit;
        logic        rex_x_bit;
    } t_ea_req;

    typedef struct packed {
        logic        is_register;
        logic        base_valid;
        logic [3:0]  base_reg;
        logic        index_valid;
        logic [3:0]  index_reg;
        logic [1:0]  scale_log2;
        logic [1:0]  disp_kind;
        logic [31:0] displacement;
        logic        rip_relative;
        logic [1:0]  size_hint;
        logic [2:0]  bytes_used;
    } t_ea_res;

endpackage

### hdl/eadec_req_if.sv
// Request channel: valid/ready handshake carrying one ModRM item.
// Depends on eadec_pkg.
interface eadec_req_if import eadec_pkg::*; ();
    logic    valid;
    logic    ready;
    t_ea_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/eadec_res_if.sv
// Result channel: valid/ready handshake carrying one decoded address item.
// Depends on eadec_pkg.
interface eadec_res_if import eadec_pkg::*; ();
    logic    valid;
    logic    ready;
    t_ea_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/eadec_decode.sv
// ModRM / SIB / displacement field decode, pure combinational.
// Depends on eadec_pkg.
module eadec_decode import eadec_pkg::*; (
    input  t_ea_req    i_req,
    input  logic [1:0] i_mode_size,
    output t_ea_res    o_res
);
    logic [1:0]  mode_f;
    logic [2:0]  rm;
    logic [7:0]  sib;
    logic        sib_used;
    logic [31:0] win;
    logic [2:0]  disp_len;

    assign mode_f = i_req.modrm_byte[7:6];
    assign rm     = i_req.modrm_byte[2:0];
    assign sib    = i_req.following_bytes[7:0];

    always_comb begin
        o_res    = '0;
        sib_used = 1'b0;
        win      = '0;
        disp_len = '0;
        if (mode_f == MOD_REG) begin
            o_res.is_register = 1'b1;
            o_res.base_valid  = 1'b1;
            o_res.base_reg    = {i_req.rex_b_bit, rm};
        end else if (i_req.addr_size == SZ_16) begin
            o_res.base_valid = 1'b1;
            o_res.base_reg   = BASE16[rm];
            if (!rm[2]) begin
                o_res.index_valid = 1'b1;
                o_res.index_reg   = INDEX16[rm[1:0]];
            end
            o_res.disp_kind = (mode_f == MOD_DISP8) ? DISP_8 :
                              (mode_f == MOD_DISPW) ? DISP_16 : DISP_NONE;
            if (mode_f == MOD_NODISP && rm == RM_DISP16) begin
                o_res.base_valid = 1'b0;
                o_res.base_reg   = '0;
                o_res.disp_kind  = DISP_16;
                o_res.size_hint  = (i_mode_size != SZ_16) ? HINT_WORD : HINT_NONE;
            end
        end else begin
            o_res.base_valid = 1'b1;
            o_res.base_reg   = {i_req.rex_b_bit, rm};
            o_res.disp_kind  = (mode_f == MOD_DISP8) ? DISP_8 :
                               (mode_f == MOD_DISPW) ? DISP_32 : DISP_NONE;
            if (mode_f == MOD_NODISP && rm == RM_DISP32) begin
                // rip-relative only when the code segment is 64-bit
                o_res.rip_relative = i_mode_size[1];
                o_res.size_hint    = i_req.addr_size[1] ? HINT_NONE : HINT_DWORD;
                o_res.base_valid   = 1'b0;
                o_res.base_reg     = '0;
                o_res.disp_kind    = DISP_32;
            end
            if (rm == RM_SIB) begin
                sib_used         = 1'b1;
                o_res.scale_log2 = sib[7:6];
                if (!(sib[5:3] == SIB_NO_IDX && !i_req.rex_x_bit)) begin
                    o_res.index_valid = 1'b1;
                    o_res.index_reg   = {i_req.rex_x_bit, sib[5:3]};
                end
                if (sib[2:0] == SIB_NO_BASE && mode_f == MOD_NODISP) begin
                    o_res.base_valid = 1'b0;
                    o_res.base_reg   = '0;
                    o_res.disp_kind  = DISP_32;
                end else begin
                    o_res.base_reg = {i_req.rex_b_bit, sib[2:0]};
                end
                if (i_mode_size != SZ_32) begin
                    o_res.size_hint = HINT_DWORD;
                end
            end
        end

        // displacement starts right after the SIB byte when there is one
        win = sib_used ? i_req.following_bytes[39:8] : i_req.following_bytes[31:0];
        case (o_res.disp_kind)
            DISP_8: begin
                o_res.displacement = {{24{win[7]}}, win[7:0]};
                disp_len = 3'd1;
            end
            DISP_16: begin
                o_res.displacement = {16'd0, win[15:0]};
                disp_len = 3'd2;
            end
            DISP_32: begin
                o_res.displacement = win;
                disp_len = 3'd4;
            end
            default: begin
                o_res.displacement = '0;
                disp_len = 3'd0;
            end
        endcase
        o_res.bytes_used = {2'd0, sib_used} + disp_len;
    end
endmodule

### hdl/x86_effective_address_decoder_core.sv
// Path from request accept to result valid: input reg, then result reg.
// One item per cycle if not stalled; decode sits between the two register stages.
// A stalled result holds in the output register while the input stage fills.
// Reset (synchronous, active low) empties both stages and sets mode_size to 32-bit.
// Depends on eadec_pkg, eadec_req_if, eadec_res_if, eadec_decode.
module x86_effective_address_decoder_core import eadec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    eadec_req_if.sink  i_req,
    eadec_res_if.source o_res
);
    logic [1:0] r_mode_size;
    logic       r_s1_valid;
    t_ea_req    r_s1_req;
    logic       r_out_valid;
    t_ea_res    r_out;
    t_ea_res    n_out;
    logic       out_free;
    logic       s1_free;

    assign out_free = !r_out_valid || o_res.ready;
    assign s1_free  = !r_s1_valid || out_free;

    assign i_req.ready = s1_free;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    eadec_decode u_decode (
        .i_req       (r_s1_req),
        .i_mode_size (r_mode_size),
        .o_res       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_size <= SZ_32;
        end else if (i_cfg_we) begin
            r_mode_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s1_free && i_req.valid) begin
            r_s1_req <= i_req.data;
        end
        if (out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_req)))
        else $error("input stage lost an item while the result stalled");

    a_reg_form_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_register) |->
        (!r_out.index_valid && r_out.disp_kind == DISP_NONE && r_out.bytes_used == 3'd0))
        else $error("register form carries memory fields");

    a_no_disp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.disp_kind == DISP_NONE) |-> (r_out.displacement == 32'd0))
        else $error("displacement set without a displacement kind");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");
`endif
endmodule
